// ----- hdl/edf_pkg.sv -----
package edf_pkg;

	localparam logic [7:0] QUANTUM_RESET = 8'd10;
	localparam logic [23:0] CLOCK_MAX = 24'hFFFFFF;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		KIND_ADDED    = 3'd0,
		KIND_REJECTED = 3'd1,
		KIND_MISSED   = 3'd2,
		KIND_SLICE    = 3'd3,
		KIND_IDLE     = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_TICK,
		ST_SLICE
	} state_t;

	typedef struct packed {
		op_t         opcode;
		logic [7:0]  task_id;
		logic [15:0] burst;
		logic [23:0] deadline;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  task_id_res;
		logic [23:0] deadline_res;
		logic [7:0]  slice_time;
		logic [15:0] remaining;
		logic        finished;
		logic [23:0] now;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [23:0] deadline;
		logic [15:0] remaining;
	} slot_t;

endpackage

// ----- hdl/edf_slot_mem.sv -----
module edf_slot_mem #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output edf_pkg::slot_t rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  edf_pkg::slot_t wr_data
);
	import edf_pkg::*;

	slot_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/edf_seq.sv -----
module edf_seq #(
	parameter int TASK_SLOTS = 16,
	localparam int IDX_W = $clog2(TASK_SLOTS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  edf_pkg::in_item_t   in_item,
	input  logic                out_free,
	output logic                res_valid,
	output edf_pkg::out_item_t  res_item,
	input  logic [7:0]          quantum_cfg,
	output logic                mem_rd_en,
	output logic [IDX_W-1:0]    mem_rd_addr,
	input  edf_pkg::slot_t      mem_rd_data,
	output logic                mem_wr_en,
	output logic [IDX_W-1:0]    mem_wr_addr,
	output edf_pkg::slot_t      mem_wr_data
);
	import edf_pkg::*;

	localparam int CNT_W = $clog2(TASK_SLOTS + 1);

	state_t               state_q, state_d;
	in_item_t             item_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TASK_SLOTS-1:0] valid_q;
	logic [23:0]          now_q;
	logic [7:0]           last_slice_q;
	logic                 eval_vld_s1;
	logic [IDX_W-1:0]     eval_idx_s1;
	logic                 best_found_q;
	logic [IDX_W-1:0]     best_idx_q;
	slot_t                best_q;

	logic [IDX_W-1:0]     cnt_idx;
	logic                 slot_free, add_last;
	logic                 issue, miss_s1, stall, take_best;
	logic [24:0]          now_sum;
	logic [23:0]          now_sat;
	logic [15:0]          quantum, slice, new_rem;
	logic                 fin;

	assign cnt_idx   = cnt_q[IDX_W-1:0];
	assign slot_free = !valid_q[cnt_idx];
	assign add_last  = (cnt_q == CNT_W'(TASK_SLOTS - 1));
	assign issue     = (cnt_q != CNT_W'(TASK_SLOTS));
	assign miss_s1   = eval_vld_s1 && valid_q[eval_idx_s1] && (now_q > mem_rd_data.deadline);
	assign stall     = miss_s1 && !out_free;
	assign take_best = eval_vld_s1 && valid_q[eval_idx_s1]
		&& (!best_found_q || (mem_rd_data.deadline < best_q.deadline));

	assign now_sum = {1'b0, now_q} + {17'd0, last_slice_q};
	assign now_sat = now_sum[24] ? CLOCK_MAX : now_sum[23:0];

	assign quantum = (quantum_cfg == 8'd0) ? 16'd1 : {8'd0, quantum_cfg};
	assign slice   = (best_q.remaining < quantum) ? best_q.remaining : quantum;
	assign new_rem = best_q.remaining - slice;
	assign fin     = (new_rem == 16'd0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_item.opcode == OP_TICK) ? ST_TICK : ST_ADD;
				end
			end
			ST_ADD: begin
				if ((slot_free || add_last) && out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_TICK: begin
				if (!issue && !eval_vld_s1) begin
					state_d = ST_SLICE;
				end
			end
			ST_SLICE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		res_valid   = 1'b0;
		res_item    = '0;
		res_item.now = now_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = cnt_idx;
		mem_wr_en   = 1'b0;
		mem_wr_addr = cnt_idx;
		mem_wr_data = '{id: item_q.task_id, deadline: item_q.deadline,
			remaining: item_q.burst};
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_ADD: begin
				if (slot_free || add_last) begin
					res_valid             = out_free;
					res_item.kind         = slot_free ? KIND_ADDED : KIND_REJECTED;
					res_item.task_id_res  = item_q.task_id;
					res_item.deadline_res = item_q.deadline;
					res_item.last         = 1'b1;
					mem_wr_en             = slot_free && out_free;
				end
			end
			ST_TICK: begin
				mem_rd_en = issue && !stall;
				if (miss_s1) begin
					res_valid             = out_free;
					res_item.kind         = KIND_MISSED;
					res_item.task_id_res  = mem_rd_data.id;
					res_item.deadline_res = mem_rd_data.deadline;
					res_item.remaining    = mem_rd_data.remaining;
				end
			end
			ST_SLICE: begin
				res_valid     = out_free;
				res_item.last = 1'b1;
				if (best_found_q) begin
					res_item.kind         = KIND_SLICE;
					res_item.task_id_res  = best_q.id;
					res_item.deadline_res = best_q.deadline;
					res_item.slice_time   = slice[7:0];
					res_item.remaining    = new_rem;
					res_item.finished     = fin;
					mem_wr_en             = out_free;
					mem_wr_addr           = best_idx_q;
					mem_wr_data           = '{id: best_q.id, deadline: best_q.deadline,
						remaining: new_rem};
				end else begin
					res_item.kind = KIND_IDLE;
				end
			end
		endcase
	end

	// writes only in ADD and SLICE, reads only in TICK: no overlap on an entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			valid_q      <= '0;
			now_q        <= '0;
			last_slice_q <= '0;
			eval_vld_s1  <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid) begin
				cnt_q        <= '0;
				eval_vld_s1  <= 1'b0;
				best_found_q <= 1'b0;
				if (in_item.opcode == OP_TICK) begin
					now_q <= now_sat;
				end
			end
			if (state_q == ST_ADD) begin
				if (mem_wr_en) begin
					valid_q[cnt_idx] <= 1'b1;
				end else if (!slot_free && !add_last) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (state_q == ST_TICK && !stall) begin
				eval_vld_s1 <= issue;
				cnt_q       <= cnt_q + CNT_W'(issue);
				if (take_best) begin
					best_found_q <= 1'b1;
				end
			end
			if (state_q == ST_SLICE && out_free) begin
				last_slice_q <= best_found_q ? slice[7:0] : 8'd0;
				if (best_found_q && fin) begin
					valid_q[best_idx_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_item;
		end
		if (state_q == ST_TICK && !stall) begin
			eval_idx_s1 <= cnt_idx;
			if (take_best) begin
				best_idx_q <= eval_idx_s1;
				best_q     <= mem_rd_data;
			end
		end
	end

endmodule

// ----- hdl/edf_task_scheduler.sv -----
// Add: one valid bit examined per cycle, from slot 0 until a free slot or the last slot;
//   the next input is taken after the result is loaded into the output register.
// Tick: one slot read per cycle while no miss result waits on the output; the next input
//   is taken after the last result. Both stall while a result waits on the output.
// Reset clears valid bits, clock, last slice and output valid; quantum resets to 10.
// Slot memory is not cleared: entries are only read behind a set valid bit.
module edf_task_scheduler #(
	parameter int TASK_SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  edf_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output edf_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_data
);
	import edf_pkg::*;

	localparam int IDX_W = $clog2(TASK_SLOTS);

	logic [7:0]       quantum_q;
	logic             out_free;
	logic             res_valid;
	out_item_t        res_item;
	logic             mem_rd_en, mem_wr_en;
	logic [IDX_W-1:0] mem_rd_addr, mem_wr_addr;
	slot_t            mem_rd_data, mem_wr_data;

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				quantum_q <= cfg_data;
			end
			if (res_valid) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_item <= res_item;
		end
	end

	edf_seq #(.TASK_SLOTS(TASK_SLOTS)) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.out_free    (out_free),
		.res_valid   (res_valid),
		.res_item    (res_item),
		.quantum_cfg (quantum_q),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data)
	);

	edf_slot_mem #(.DEPTH(TASK_SLOTS)) u_mem (
		.clk    (clk),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data)
	);

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!out_valid || out_ready))
		else $error("result loaded over a pending transfer");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready held after an input transfer");

	a_miss_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.kind == KIND_MISSED) |-> !out_item.last)
		else $error("miss result marked last");

	a_zero_slice_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.kind == KIND_SLICE && out_item.slice_time == 8'd0)
		|-> out_item.finished)
		else $error("empty slice on an unfinished task");
`endif

endmodule
